### hw/rtl/jss_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi stencil sweep package
// Shared sizes, stage payload type and pipeline control type.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int MAX_GRID   = 256;
  localparam int LINE_DEPTH = MAX_GRID + 2;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 9;
  localparam int SUM_W      = SAMPLE_W + 2;

  // Stage 1 payload: neighbor sum plus what the update stage needs
  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] center;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic                last;
    logic                first;
  } s1_t;

  // Pipeline advance controls from the top level
  typedef struct packed {
    logic accept;
    logic adv1;
    logic adv2;
  } pipe_ctrl_t;

endpackage

### hw/rtl/jacobi_stencil_sweep.sv
// ----------------------------------------------------------------------------
// Jacobi stencil sweep
// One five-point Jacobi sweep over a streamed square grid.
// ----------------------------------------------------------------------------
// The grid, boundary ring included, streams in row-major order, one unsigned
// Q1.15 sample per item; grid_size sets the interior edge length (0 acts as
// 1, values above 256 as 256) and writing it restarts the sweep at the top
// left corner. The block takes one sample per clock cycle while in_stall_o
// is low: two line buffer RAMs of 258 entries with one read and one write
// port each are read one column ahead, so every sample finds its neighbors
// ready. The sample just below an interior point loads the neighbor sum
// into the first register stage at the edge that takes it; the average,
// change and running maximum then land in the result register once it is
// free. A stalled result does not stop input until the one item between
// the stages is also waiting. Line buffer contents are not cleared at reset
// and need no clearing pass.
module jacobi_stencil_sweep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jss_pkg::POS_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [jss_pkg::SAMPLE_W-1:0]  sample_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [jss_pkg::SAMPLE_W-1:0]  new_value_o,
  output logic [jss_pkg::POS_W-1:0]     point_row_o,
  output logic [jss_pkg::POS_W-1:0]     point_col_o,
  output logic [jss_pkg::SAMPLE_W-1:0]  max_difference_o,
  output logic                          last_o
);
  import jss_pkg::*;

  pipe_ctrl_t ctrl;
  logic       s1_valid;
  s1_t        s1;

  // Advance each stage when its downstream register frees up
  assign ctrl.adv2   = !out_valid_o || !out_stall_i;
  assign ctrl.adv1   = !s1_valid || ctrl.adv2;
  assign ctrl.accept = in_valid_i && ctrl.adv1;
  assign in_stall_o  = !ctrl.adv1;

  jss_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .sample_value_i (sample_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s1_valid_o     (s1_valid),
    .s1_o           (s1)
  );

  jss_update u_update (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv2_i           (ctrl.adv2),
    .s1_valid_i       (s1_valid),
    .s1_i             (s1),
    .out_valid_o      (out_valid_o),
    .new_value_o      (new_value_o),
    .point_row_o      (point_row_o),
    .point_col_o      (point_col_o),
    .max_difference_o (max_difference_o),
    .last_o           (last_o)
  );

  // The last point of a sweep sits on the diagonal
  a_last_diag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> point_row_o == point_col_o)
    else $error("last item off the diagonal");

  // Results only name interior points
  a_interior : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (point_row_o != '0) && (point_col_o != '0))
    else $error("result on boundary position");

  // An empty result register never holds back input
  a_no_stall_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // Hold a stalled result steady
  a_hold_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
    $stable({new_value_o, point_row_o, point_col_o, max_difference_o, last_o}))
    else $error("stalled result changed");

endmodule

### hw/rtl/jss_line_ram.sv
// ----------------------------------------------------------------------------
// Line buffer RAM
// One row of samples: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module jss_line_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [jss_pkg::ADDR_W-1:0]    waddr_i,
  input  logic [jss_pkg::SAMPLE_W-1:0]  wdata_i,
  input  logic [jss_pkg::ADDR_W-1:0]    raddr_i,
  output logic [jss_pkg::SAMPLE_W-1:0]  rdata_o
);
  import jss_pkg::*;

  logic [SAMPLE_W-1:0] mem_q [LINE_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/jss_window.sv
// ----------------------------------------------------------------------------
// Stencil window
// Raster position, grid size register, line buffers, neighbor window and
// the stage 1 register holding the four-neighbor sum.
// ----------------------------------------------------------------------------
module jss_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jss_pkg::pipe_ctrl_t           ctrl_i,
  input  logic [jss_pkg::SAMPLE_W-1:0]  sample_value_i,
  input  logic                          cfg_we_i,
  input  logic [jss_pkg::POS_W-1:0]     cfg_wdata_i,
  output logic                          s1_valid_o,
  output jss_pkg::s1_t                  s1_o
);
  import jss_pkg::*;

  logic [POS_W-1:0]    grid_q, grid_d;
  logic [POS_W-1:0]    row_q, row_d;
  logic [POS_W-1:0]    col_q, col_d;
  logic [SAMPLE_W-1:0] col0_q;
  logic [SAMPLE_W-1:0] center_q;
  logic [SAMPLE_W-1:0] left_q;
  logic                s1_valid_q;
  s1_t                 s1_q, s1_d;

  logic [POS_W:0]      grid_p1;
  logic [POS_W:0]      nxt_col;
  logic [ADDR_W-1:0]   new_raddr, old_raddr;
  logic [SAMPLE_W-1:0] up_rd, right_rd, cur_center;
  logic                interior;

  // Grid size with zero and oversize clamped
  always_comb begin
    grid_d = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      grid_d = POS_W'(1);
    end else if (int'(cfg_wdata_i) > MAX_GRID) begin
      grid_d = POS_W'(MAX_GRID);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= POS_W'(MAX_GRID);
    end else if (cfg_we_i) begin
      grid_q <= grid_d;
    end
  end

  assign grid_p1 = {1'b0, grid_q} + 1'b1;

  // Advance raster position, restart on config write
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (ctrl_i.accept) begin
      if ({1'b0, col_q} >= grid_p1) begin
        col_d = '0;
        row_d = ({1'b0, row_q} >= grid_p1) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Read addresses follow the next position so data is ready at accept
  assign nxt_col   = {1'b0, col_d} + 1'b1;
  assign new_raddr = (nxt_col > (POS_W+1)'(LINE_DEPTH - 1)) ?
                     ADDR_W'(LINE_DEPTH - 1) : ADDR_W'(nxt_col);
  assign old_raddr = ADDR_W'(col_d);

  // Column zero of the previous row lives in a register
  assign cur_center = (col_q == '0) ? col0_q : center_q;

  // Row r-1: written with each sample, read one column ahead
  jss_line_ram u_newer (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.accept),
    .waddr_i (ADDR_W'(col_q)),
    .wdata_i (sample_value_i),
    .raddr_i (new_raddr),
    .rdata_o (right_rd)
  );

  // Row r-2: takes the row r-1 value as it is replaced
  jss_line_ram u_older (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.accept && (col_q != '0)),
    .waddr_i (ADDR_W'(col_q)),
    .wdata_i (cur_center),
    .raddr_i (old_raddr),
    .rdata_o (up_rd)
  );

  // Slide the neighbor window
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      left_q   <= cur_center;
      center_q <= right_rd;
      if (col_q == '0) begin
        col0_q <= sample_value_i;
      end
    end
  end

  // Stage 1: neighbor sum and point flags
  assign interior = (row_q >= POS_W'(2)) && ({1'b0, row_q} <= grid_p1) &&
                    (col_q >= POS_W'(1)) && (col_q <= grid_q);

  always_comb begin
    s1_d.sum    = SUM_W'(up_rd) + SUM_W'(sample_value_i) +
                  SUM_W'(left_q) + SUM_W'(right_rd);
    s1_d.center = cur_center;
    s1_d.row    = row_q - 1'b1;
    s1_d.col    = col_q;
    s1_d.last   = ({1'b0, row_q} == grid_p1) && (col_q == grid_q);
    s1_d.first  = (row_q == POS_W'(2)) && (col_q == POS_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ctrl_i.adv1) begin
      s1_valid_q <= ctrl_i.accept && interior;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

### hw/rtl/jss_update.sv
// ----------------------------------------------------------------------------
// Point update stage
// Averages the neighbor sum, tracks the running maximum change and holds
// the result register.
// ----------------------------------------------------------------------------
module jss_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv2_i,
  input  logic                          s1_valid_i,
  input  jss_pkg::s1_t                  s1_i,
  output logic                          out_valid_o,
  output logic [jss_pkg::SAMPLE_W-1:0]  new_value_o,
  output logic [jss_pkg::POS_W-1:0]     point_row_o,
  output logic [jss_pkg::POS_W-1:0]     point_col_o,
  output logic [jss_pkg::SAMPLE_W-1:0]  max_difference_o,
  output logic                          last_o
);
  import jss_pkg::*;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] new_value_q, max_q;
  logic [POS_W-1:0]    row_q, col_q;
  logic                last_q;
  logic [SAMPLE_W-1:0] nv, diff, max_d;

  // Quarter of the sum, change from the old value, running max
  assign nv    = s1_i.sum[SUM_W-1:2];
  assign diff  = (nv >= s1_i.center) ? nv - s1_i.center : s1_i.center - nv;
  assign max_d = (s1_i.first || (diff > max_q)) ? diff : max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv2_i) begin
      out_valid_q <= s1_valid_i;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (adv2_i && s1_valid_i) begin
      new_value_q <= nv;
      max_q       <= max_d;
      row_q       <= s1_i.row;
      col_q       <= s1_i.col;
      last_q      <= s1_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign new_value_o      = new_value_q;
  assign point_row_o      = row_q;
  assign point_col_o      = col_q;
  assign max_difference_o = max_q;
  assign last_o           = last_q;

endmodule

### bench/tb_jacobi_stencil_sweep.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Jacobi stencil sweep testbench
// Streams square grids in raster order through the block, boundary ring
// included, and predicts each interior update, the running peak change and
// the end-of-sweep flag. Grid sizes are mostly small, with a partial sweep at
// the reset size and an oversize write that must saturate. Random idling and
// backpressure are applied on both sides.
// ----------------------------------------------------------------------------
module tb_jacobi_stencil_sweep;
  import jss_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int SMALL_ITEMS  = 210;
  localparam int SAT_ITEMS    = 200;

  typedef struct packed {
    logic [SAMPLE_W-1:0] new_value;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic [SAMPLE_W-1:0] max_difference;
    logic                last;
  } point_t;

  typedef enum int {
    FLAVOR_RANDOM,
    FLAVOR_RAILS,
    FLAVOR_SMOOTH,
    FLAVOR_MIXED
  } flavor_e;

  // Predict stencil updates and compare them with what the block emits
  class sweep_scoreboard;
    bit [SAMPLE_W-1:0] line_older [LINE_DEPTH];
    bit [SAMPLE_W-1:0] line_newer [LINE_DEPTH];
    int unsigned       row_pos;
    int unsigned       col_pos;
    int unsigned       peak_change;
    int unsigned       grid_reg;
    point_t            expected_points [$];
    int unsigned       fail_count;

    function new();
      row_pos     = 0;
      col_pos     = 0;
      peak_change = 0;
      grid_reg    = MAX_GRID;
      fail_count  = 0;
    endfunction

    // Store the size and restart the sweep; line contents stay
    function void set_grid(logic [POS_W-1:0] value);
      grid_reg    = value;
      row_pos     = 0;
      col_pos     = 0;
      peak_change = 0;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] sample);
      int unsigned side;
      int unsigned r;
      int unsigned c;
      int unsigned s;
      int unsigned up;
      int unsigned center;
      int unsigned right_n;
      int unsigned left_n;
      int unsigned avg;
      int unsigned change;
      point_t      p;
      side = (grid_reg == 0) ? 1 : (grid_reg > MAX_GRID) ? MAX_GRID : grid_reg;
      r = row_pos;
      c = col_pos;
      s = sample;
      up      = line_older[c];
      center  = line_newer[c];
      right_n = line_newer[(c + 1 < LINE_DEPTH) ? c + 1 : LINE_DEPTH - 1];
      left_n  = (c > 0) ? line_older[c - 1] : 0;
      // shift the column: previous row moves down, this sample enters
      line_older[c] = SAMPLE_W'(center);
      line_newer[c] = sample;
      if (r >= 2 && r <= side + 1 && c >= 1 && c <= side) begin
        avg    = ((up + s + left_n + right_n) >> 2) & 32'hFFFF;
        change = (avg >= center) ? avg - center : center - avg;
        if (change > peak_change) begin
          peak_change = change;
        end
        p.new_value      = avg[SAMPLE_W-1:0];
        p.row            = POS_W'(r - 1);
        p.col            = POS_W'(c);
        p.max_difference = peak_change[SAMPLE_W-1:0];
        p.last           = (r - 1 == side && c == side);
        expected_points.push_back(p);
      end
      // advance the raster position, wrap at the end of the sweep
      if (c >= side + 1) begin
        col_pos = 0;
        if (r >= side + 1) begin
          row_pos     = 0;
          peak_change = 0;
        end else begin
          row_pos = r + 1;
        end
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: unexpected result row %0d col %0d value %h", $time,
                   got.row, got.col, got.new_value);
        end
        return;
      end
      want = expected_points.pop_front();
      if (got.new_value !== want.new_value || got.row !== want.row ||
          got.col !== want.col || got.max_difference !== want.max_difference ||
          got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: point mismatch", $time);
          $display("  expected value %h row %0d col %0d maxdiff %h last %b",
                   want.new_value, want.row, want.col, want.max_difference, want.last);
          $display("  actual   value %h row %0d col %0d maxdiff %h last %b",
                   got.new_value, got.row, got.col, got.max_difference, got.last);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [POS_W-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [SAMPLE_W-1:0] new_value_o;
  logic [POS_W-1:0]    point_row_o;
  logic [POS_W-1:0]    point_col_o;
  logic [SAMPLE_W-1:0] max_difference_o;
  logic                last_o;

  sweep_scoreboard sb = new();
  bit              idling;

  jacobi_stencil_sweep dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_value_i   (sample_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .new_value_o      (new_value_o),
    .point_row_o      (point_row_o),
    .point_col_o      (point_col_o),
    .max_difference_o (max_difference_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hold off results in random bursts while idling is enabled
  initial begin
    forever begin
      @(posedge clk_i);
      if (idling && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_point(point_t'({new_value_o, point_row_o, point_col_o,
                               max_difference_o, last_o}));
    end
  end

  function automatic int unsigned active_side(int unsigned value);
    return (value == 0) ? 1 : (value > MAX_GRID) ? MAX_GRID : value;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(flavor_e flavor,
                                                      logic [SAMPLE_W-1:0] base);
    logic [SAMPLE_W-1:0] v;
    case (flavor)
      FLAVOR_RAILS: begin
        v = $urandom_range(0, 1) ? '1 : '0;
      end
      FLAVOR_SMOOTH: begin
        v = base + SAMPLE_W'($urandom_range(0, 31));
      end
      FLAVOR_MIXED: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          default: v = SAMPLE_W'($urandom);
        endcase
      end
      default: begin
        v = SAMPLE_W'($urandom);
      end
    endcase
    return v;
  endfunction

  // Offer one item, with a random gap first, and wait until it is taken
  task automatic send_sample(logic [SAMPLE_W-1:0] value);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(value);
  endtask

  task automatic run_sweep(int unsigned count, flavor_e flavor);
    logic [SAMPLE_W-1:0] base;
    base = SAMPLE_W'($urandom);
    repeat (count) send_sample(pick_sample(flavor, base));
  endtask

  // Drain all results, let the pipeline settle, then write the grid size
  task automatic write_grid(logic [POS_W-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_grid(value);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] pattern [9];
    int unsigned         small_items;
    int unsigned         grid_value;
    int unsigned         full_len;
    int unsigned         sweep_len;
    int unsigned         sweeps;
    flavor_e             flavor;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    sample_value_i <= '0;
    out_stall_i    <= 1'b0;
    idling = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size: the boundary row, the first interior row and the start of the next
    run_sweep(2 * (MAX_GRID + 2) + 6, FLAVOR_MIXED);

    // zero size acts as one: full-scale neighbors around a zero center
    write_grid('0);
    pattern = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hFFFF, 16'h0000,
                16'hFFFF, 16'hA5A5, 16'hFFFF, 16'hFFFF};
    foreach (pattern[i]) send_sample(pattern[i]);

    // abandon a sweep part way, then restart it with a write
    run_sweep(4, FLAVOR_RAILS);
    write_grid(9'd1);

    // truncating average, small change; peak cleared by the last sweep end
    pattern = '{16'h7FFF, 16'h0001, 16'h8000, 16'h0002, 16'h0003,
                16'h0003, 16'h0000, 16'h0004, 16'hFFFF};
    foreach (pattern[i]) send_sample(pattern[i]);

    // random phases: mostly whole sweeps on small grids, some cut short
    small_items = 0;
    while (small_items < SMALL_ITEMS) begin
      case ($urandom_range(0, 19))
        0:             grid_value = 0;
        1:             grid_value = $urandom_range(11, 16);
        2, 3, 4, 5, 6: grid_value = $urandom_range(5, 10);
        default:       grid_value = $urandom_range(1, 4);
      endcase
      idling = ($urandom_range(0, 3) != 0);
      write_grid(grid_value[POS_W-1:0]);
      full_len = (active_side(grid_value) + 2) ** 2;
      sweeps = $urandom_range(1, 3);
      for (int k = 0; k < sweeps; k++) begin
        flavor = flavor_e'($urandom_range(0, 3));
        sweep_len = full_len;
        if (k == sweeps - 1 && $urandom_range(0, 4) == 0) begin
          sweep_len = $urandom_range(1, full_len - 1);
        end
        if (sweep_len > SMALL_ITEMS - small_items) begin
          sweep_len = SMALL_ITEMS - small_items;
        end
        run_sweep(sweep_len, flavor);
        small_items += sweep_len;
      end
    end

    // oversize write saturates: long boundary row, no results, no idling
    idling = 1'b0;
    grid_value = $urandom_range(MAX_GRID + 1, 511);
    write_grid(grid_value[POS_W-1:0]);
    run_sweep(SAT_ITEMS, FLAVOR_RANDOM);

    in_valid_i <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.expected_points.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### jacobi_stencil_sweep.f
hw/rtl/jss_pkg.sv
hw/rtl/jss_line_ram.sv
hw/rtl/jss_window.sv
hw/rtl/jss_update.sv
hw/rtl/jacobi_stencil_sweep.sv
bench/tb_jacobi_stencil_sweep.sv
